// ===== hdl/i2cwr_pkg.sv =====
`default_nettype none

package i2cwr_pkg;

  // Input item kinds
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_EVENT = 2'd1;
  localparam logic [1:0] ACT_ERROR = 2'd2;
  localparam logic [1:0] ACT_LOAD  = 2'd3;

  // Bus commands
  localparam logic [3:0] CMD_ADDR     = 4'd0;
  localparam logic [3:0] CMD_DATA     = 4'd1;
  localparam logic [3:0] CMD_ACK_ON   = 4'd2;
  localparam logic [3:0] CMD_ACK_OFF  = 4'd3;
  localparam logic [3:0] CMD_START    = 4'd4;
  localparam logic [3:0] CMD_STOP     = 4'd5;
  localparam logic [3:0] CMD_RXBYTE   = 4'd6;
  localparam logic [3:0] CMD_DONE_OK  = 4'd7;
  localparam logic [3:0] CMD_DONE_ERR = 4'd8;

  localparam int TX_DEPTH_DEF   = 16;
  localparam int MAX_RX_LEN_DEF = 255;

  // Most commands one item can cause, and the slot counter width
  localparam int MAX_SLOTS = 7;
  localparam int CNT_W     = 3;
  // Store index travels in a byte field (the user must keep store depth at most 256; the block does not enforce it)
  localparam int IDX_W     = 8;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [3:0] cmd;
    logic [7:0] payload;   // store index for CMD_DATA
  } slot_t;

  typedef struct packed {
    logic [CNT_W-1:0]           cnt;
    slot_t [MAX_SLOTS-1:0]      slots;
    logic                       is_load;
    logic [IDX_W-1:0]           wr_addr;
    logic [7:0]                 wr_data;
  } entry_t;

endpackage

`default_nettype wire

// ===== hdl/i2cwr_front.sv =====
`default_nettype none

module i2cwr_front #(
  parameter int TX_DEPTH   = i2cwr_pkg::TX_DEPTH_DEF,
  parameter int MAX_RX_LEN = i2cwr_pkg::MAX_RX_LEN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire logic [1:0]        action,
  input  wire logic [6:0]        dev_addr,
  input  wire logic [4:0]        tx_count,
  input  wire logic [7:0]        rx_count,
  input  wire logic              start_sent,
  input  wire logic              addr_sent,
  input  wire logic              rx_not_empty,
  input  wire logic              tx_empty,
  input  wire logic              byte_finished,
  input  wire logic [7:0]        rx_byte,
  input  wire logic [7:0]        tx_byte,
  output logic                   push,
  output i2cwr_pkg::entry_t      ent
);

  localparam int TW = $clog2(TX_DEPTH + 1);
  localparam int RW = $clog2(MAX_RX_LEN + 1);
  localparam int PW = $clog2(TX_DEPTH);
  localparam int CW = i2cwr_pkg::CNT_W;

  logic [6:0]    target_addr, target_addr_next;
  logic [TW-1:0] tx_rem, tx_rem_next;
  logic [RW-1:0] rx_rem, rx_rem_next;
  logic [PW-1:0] rd_pos, rd_pos_next;
  logic [PW-1:0] wr_pos, wr_pos_next;

  function automatic logic [PW-1:0] step_pos(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p == PW'(TX_DEPTH - 1)) ? '0 : p + PW'(1);
    return r;
  endfunction

  always_comb begin
    logic [i2cwr_pkg::CNT_W-1:0] n;
    n                = '0;
    ent              = '0;
    target_addr_next = target_addr;
    tx_rem_next      = tx_rem;
    rx_rem_next      = rx_rem;
    rd_pos_next      = rd_pos;
    wr_pos_next      = wr_pos;
    case (action)
      i2cwr_pkg::ACT_START: begin
        target_addr_next = dev_addr;
        tx_rem_next = (32'(tx_count) > 32'(TX_DEPTH)) ? TW'(TX_DEPTH) : TW'(tx_count);
        rx_rem_next = (32'(rx_count) > 32'(MAX_RX_LEN)) ? RW'(MAX_RX_LEN) : RW'(rx_count);
        rd_pos_next = '0;
        wr_pos_next = '0;
        ent.slots[n].cmd = i2cwr_pkg::CMD_START;
        n = n + CW'(1);
      end
      i2cwr_pkg::ACT_EVENT: begin
        if (start_sent) begin
          ent.slots[n].cmd     = i2cwr_pkg::CMD_ADDR;
          ent.slots[n].payload = {target_addr, (tx_rem_next == '0)};
          n = n + CW'(1);
        end
        if (addr_sent) begin
          if (tx_rem_next != '0) begin
            ent.slots[n].cmd     = i2cwr_pkg::CMD_DATA;
            ent.slots[n].payload = 8'(rd_pos_next);
            rd_pos_next = step_pos(rd_pos_next);
            tx_rem_next = tx_rem_next - TW'(1);
          end else if (rx_rem_next > RW'(1)) begin
            ent.slots[n].cmd = i2cwr_pkg::CMD_ACK_ON;
          end else begin
            ent.slots[n].cmd = i2cwr_pkg::CMD_STOP;
          end
          n = n + CW'(1);
        end
        if (rx_not_empty && (rx_rem_next != '0)) begin
          ent.slots[n].cmd     = i2cwr_pkg::CMD_RXBYTE;
          ent.slots[n].payload = rx_byte;
          n = n + CW'(1);
          rx_rem_next = rx_rem_next - RW'(1);
          if (rx_rem_next == RW'(1)) begin
            ent.slots[n].cmd = i2cwr_pkg::CMD_ACK_OFF;
            n = n + CW'(1);
            ent.slots[n].cmd = i2cwr_pkg::CMD_STOP;
            n = n + CW'(1);
          end else if (rx_rem_next == '0) begin
            ent.slots[n].cmd = i2cwr_pkg::CMD_DONE_OK;
            n = n + CW'(1);
          end
        end
        if (tx_empty && !byte_finished) begin
          if (tx_rem_next != '0) begin
            ent.slots[n].cmd     = i2cwr_pkg::CMD_DATA;
            ent.slots[n].payload = 8'(rd_pos_next);
            rd_pos_next = step_pos(rd_pos_next);
            tx_rem_next = tx_rem_next - TW'(1);
            n = n + CW'(1);
          end else if (rx_rem_next != '0) begin
            ent.slots[n].cmd = i2cwr_pkg::CMD_START;
            n = n + CW'(1);
          end else begin
            ent.slots[n].cmd = i2cwr_pkg::CMD_STOP;
            n = n + CW'(1);
            ent.slots[n].cmd = i2cwr_pkg::CMD_DONE_OK;
            n = n + CW'(1);
          end
        end
      end
      i2cwr_pkg::ACT_ERROR: begin
        ent.slots[0].cmd = i2cwr_pkg::CMD_STOP;
        ent.slots[1].cmd = i2cwr_pkg::CMD_DONE_ERR;
        n = CW'(2);
        tx_rem_next = '0;
        rx_rem_next = '0;
      end
      i2cwr_pkg::ACT_LOAD: begin
        ent.is_load = 1'b1;
        ent.wr_addr = i2cwr_pkg::IDX_W'(wr_pos);
        ent.wr_data = tx_byte;
        wr_pos_next = step_pos(wr_pos);
      end
      default: begin
      end
    endcase
    ent.cnt = n;
    // Drop status events that cause no command
    push = take && (ent.is_load || (n != '0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_addr <= '0;
      tx_rem      <= '0;
      rx_rem      <= '0;
      rd_pos      <= '0;
      wr_pos      <= '0;
    end else if (take) begin
      target_addr <= target_addr_next;
      tx_rem      <= tx_rem_next;
      rx_rem      <= rx_rem_next;
      rd_pos      <= rd_pos_next;
      wr_pos      <= wr_pos_next;
    end
  end

  a_tx_bound: assert property (@(posedge clk) disable iff (rst)
    32'(tx_rem) <= 32'(TX_DEPTH))
    else $error("write count above store depth");

  a_rx_bound: assert property (@(posedge clk) disable iff (rst)
    32'(rx_rem) <= 32'(MAX_RX_LEN))
    else $error("read count above limit");

endmodule

`default_nettype wire

// ===== hdl/i2cwr_queue.sv =====
`default_nettype none

module i2cwr_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire i2cwr_pkg::entry_t  push_ent,
  output logic                    not_full,
  input  wire logic               pop,
  output logic                    head_valid,
  output i2cwr_pkg::entry_t       head
);

  localparam int AW = $clog2(i2cwr_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(i2cwr_pkg::QUEUE_DEPTH + 1);

  i2cwr_pkg::entry_t q [i2cwr_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [CW-1:0] count;

  assign not_full   = (count != CW'(i2cwr_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = q[rptr];

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    r = (p == AW'(i2cwr_pkg::QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= adv(wptr);
      end
      if (pop) begin
        rptr <= adv(rptr);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !not_full) && !(pop && !head_valid))
    else $error("queue push while full or pop while empty");

endmodule

`default_nettype wire

// ===== hdl/i2cwr_back.sv =====
`default_nettype none

module i2cwr_back #(
  parameter int TX_DEPTH = i2cwr_pkg::TX_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               head_valid,
  input  wire i2cwr_pkg::entry_t  head,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [3:0]              out_cmd,
  output logic [7:0]              out_payload,
  output logic                    out_last
);

  localparam int PW = $clog2(TX_DEPTH);

  logic [7:0] store [TX_DEPTH];
  logic [7:0] store_q;

  logic [i2cwr_pkg::CNT_W-1:0] idx;
  logic [3:0] cmd_r;
  logic [7:0] payload_r;
  logic       last_r;
  logic       from_store;

  i2cwr_pkg::slot_t cur;
  logic load_go, emit_go, at_last;

  assign cur     = head.slots[idx];
  assign at_last = (idx == head.cnt - i2cwr_pkg::CNT_W'(1));
  assign load_go = head_valid && head.is_load;
  assign emit_go = head_valid && !head.is_load && (!out_valid || out_ready);
  assign pop     = load_go || (emit_go && at_last);

  assign out_cmd     = cmd_r;
  assign out_payload = from_store ? store_q : payload_r;
  assign out_last    = last_r;

  // Store writes and reads happen in queue order, one per cycle; reads wait while the output is held
  always_ff @(posedge clk) begin
    if (load_go) begin
      store[PW'(head.wr_addr)] <= head.wr_data;
    end
    if (emit_go) begin
      store_q <= store[PW'(cur.payload)];
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      cmd_r      <= cur.cmd;
      payload_r  <= cur.payload;
      last_r     <= at_last;
      from_store <= (cur.cmd == i2cwr_pkg::CMD_DATA);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit_go) begin
        idx       <= at_last ? '0 : idx + i2cwr_pkg::CNT_W'(1);
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (head_valid && !head.is_load) |-> (head.cnt != '0 && idx < head.cnt))
    else $error("slot index outside command list");

endmodule

`default_nettype wire

// ===== hdl/i2c_master_write_read_sequencer_unit.sv =====
// Flow: the first command of an item passes the command queue and the output register
//   before it shows on the master side; further commands of the same item follow one per
//   cycle while the master side is ready. Throughput: one input word per cycle while the
//   two-entry command queue has room; the back end drives one command word per cycle while
//   m_axis_tready allows; a store load gives no command and an empty event is not queued.
// Reset (rst, synchronous): clears counts, store positions, queue and output; store is kept.
`default_nettype none

module i2c_master_write_read_sequencer_unit #(
  parameter int TX_DEPTH   = i2cwr_pkg::TX_DEPTH_DEF,
  parameter int MAX_RX_LEN = i2cwr_pkg::MAX_RX_LEN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // dev_addr[6:0], tx_count[11:7], rx_count[19:12], start_sent[20], addr_sent[21],
  // rx_not_empty[22], tx_empty[23], byte_finished[24], rx_byte[32:25], tx_byte[40:33]
  input  wire logic [47:0] s_axis_tdata,
  // action[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // command[3:0], payload[11:4]
  output logic [15:0]      m_axis_tdata,
  output logic             m_axis_tlast
);

  logic              take;
  logic              push;
  i2cwr_pkg::entry_t push_ent;
  logic              q_not_full;
  logic              head_valid;
  i2cwr_pkg::entry_t head;
  logic              pop;
  logic [3:0]        out_cmd;
  logic [7:0]        out_payload;

  // Accept whenever the queue can hold one more command list
  assign s_axis_tready = q_not_full;
  assign take          = s_axis_tvalid && q_not_full;

  // Front: track the transaction and turn each word into a command list
  i2cwr_front #(
    .TX_DEPTH   (TX_DEPTH),
    .MAX_RX_LEN (MAX_RX_LEN)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .action        (s_axis_tuser),
    .dev_addr      (s_axis_tdata[6:0]),
    .tx_count      (s_axis_tdata[11:7]),
    .rx_count      (s_axis_tdata[19:12]),
    .start_sent    (s_axis_tdata[20]),
    .addr_sent     (s_axis_tdata[21]),
    .rx_not_empty  (s_axis_tdata[22]),
    .tx_empty      (s_axis_tdata[23]),
    .byte_finished (s_axis_tdata[24]),
    .rx_byte       (s_axis_tdata[32:25]),
    .tx_byte       (s_axis_tdata[40:33]),
    .push          (push),
    .ent           (push_ent)
  );

  // Decouple the two halves so a stalled bus side does not block the front until the queue fills
  i2cwr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ent   (push_ent),
    .not_full   (q_not_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back: own the transmit store, serialize commands into the output register
  i2cwr_back #(
    .TX_DEPTH (TX_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_cmd     (out_cmd),
    .out_payload (out_payload),
    .out_last    (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, out_payload, out_cmd};

endmodule

`default_nettype wire
